### design/gbb_pkg.sv
`default_nettype none

package gbb_pkg;

  localparam int MAX_FONT_SIZE = 24;
  localparam int MIN_FONT_SIZE = 12;
  localparam int DEFAULT_SIZE  = 16;
  localparam int FRAME_DIM     = 1024;
  localparam int TOP_BIT       = 5;

  localparam int SIZE_W  = 5;
  localparam int DIM_W   = 11;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = 20;
  localparam int VAL_W   = 6;
  localparam int COUNT_W = 10;
  localparam int CFG_W   = 16;
  localparam int BIT_W   = $clog2(TOP_BIT + 1);

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [1:0] CFG_FONT_SIZE     = 2'd0;
  localparam logic [1:0] CFG_ROW_PITCH     = 2'd1;
  localparam logic [1:0] CFG_BUFFER_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_INK_COLOR     = 2'd3;

  // one classified byte waiting for the walker
  typedef struct packed {
    logic [VAL_W-1:0]        val;
    logic                    start;
    logic signed [DIM_W-1:0] ox;
    logic signed [DIM_W-1:0] oy;
    logic                    narrow;
  } item_t;

  // one walked pixel: write says it lands in the buffer, eob marks bit 0
  typedef struct packed {
    logic             valid;
    logic             write;
    logic             eob;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
  } step_t;

  // alphabet: 0-9, a-z, A-Z, @ # * $ ; index kept to six bits
  function automatic logic [VAL_W-1:0] symbol_value(input logic [7:0] b);
    logic [7:0] idx;
    idx = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) idx = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h7a) idx = b - 8'h61 + 8'd10;
    else if (b >= 8'h41 && b <= 8'h5a) idx = b - 8'h41 + 8'd36;
    else if (b == 8'h40) idx = 8'd62;
    else if (b == 8'h23) idx = 8'd63;
    else if (b == 8'h2a) idx = 8'd64;
    else if (b == 8'h24) idx = 8'd65;
    return idx[VAL_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] fs);
    if (32'(fs) < MIN_FONT_SIZE || 32'(fs) > MAX_FONT_SIZE)
      return SIZE_W'(DEFAULT_SIZE);
    return fs;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (32'(v) > FRAME_DIM)
      return DIM_W'(FRAME_DIM);
    return v;
  endfunction

endpackage

`default_nettype wire

### design/gbb_front.sv
`default_nettype none

module gbb_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    code_byte,
  input  wire logic                          glyph_start,
  input  wire logic signed [gbb_pkg::DIM_W-1:0] origin_x,
  input  wire logic signed [gbb_pkg::DIM_W-1:0] origin_y,
  input  wire logic                          narrow_cell,
  output logic                               q_valid,
  output gbb_pkg::item_t                     q_item,
  input  wire logic                          q_pop
);

  gbb_pkg::item_t slots [gbb_pkg::QDEPTH];
  logic [gbb_pkg::QPTR_W-1:0] wr_ptr;
  logic [gbb_pkg::QPTR_W-1:0] rd_ptr;
  logic [gbb_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;
  gbb_pkg::item_t entry;

  assign in_stall = (count == gbb_pkg::QCNT_W'(gbb_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_comb begin
    entry.val    = gbb_pkg::symbol_value(code_byte);
    entry.start  = glyph_start;
    entry.ox     = origin_x;
    entry.oy     = origin_y;
    entry.narrow = narrow_cell;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == gbb_pkg::QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == gbb_pkg::QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/gbb_walk.sv
`default_nettype none

module gbb_walk (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [gbb_pkg::SIZE_W-1:0]   font_size,
  input  wire logic [gbb_pkg::DIM_W-1:0]    pitch,
  input  wire logic [gbb_pkg::DIM_W-1:0]    height,
  input  wire logic                         q_valid,
  input  wire gbb_pkg::item_t               q_item,
  output logic                              q_pop,
  output gbb_pkg::step_t                    w,
  input  wire logic                         w_take
);

  logic                                 b_valid;
  logic [gbb_pkg::VAL_W-1:0]            val;
  logic [gbb_pkg::BIT_W-1:0]            bit_idx;
  logic [gbb_pkg::COUNT_W-1:0]          pixel_count;
  logic [gbb_pkg::SIZE_W-1:0]           cell_row;
  logic [gbb_pkg::SIZE_W-1:0]           cell_col;
  logic signed [gbb_pkg::DIM_W-1:0]     glyph_x;
  logic signed [gbb_pkg::DIM_W-1:0]     glyph_y;
  logic                                 glyph_narrow;

  logic [gbb_pkg::SIZE_W-1:0]           s;
  logic [gbb_pkg::COUNT_W-1:0]          total;
  logic [gbb_pkg::SIZE_W-1:0]           cell_w;
  logic signed [gbb_pkg::DIM_W:0]       bx;
  logic signed [gbb_pkg::DIM_W:0]       by;
  logic                                 exhausted;
  logic                                 hit;
  logic                                 in_buf;
  logic [gbb_pkg::SIZE_W:0]             col_inc;
  logic                                 col_wrap;
  logic                                 w_free;
  logic                                 step;
  logic                                 last_step;

  always_comb begin
    s         = gbb_pkg::eff_size(font_size);
    total     = gbb_pkg::COUNT_W'(s) * gbb_pkg::COUNT_W'(s);
    cell_w    = glyph_narrow ? (s >> 1) : s;
    exhausted = (pixel_count >= total);
    hit       = (cell_col < cell_w) && val[bit_idx];
    bx        = {glyph_x[gbb_pkg::DIM_W-1], glyph_x}
              + $signed({{(gbb_pkg::DIM_W-gbb_pkg::SIZE_W+1){1'b0}}, cell_col});
    by        = {glyph_y[gbb_pkg::DIM_W-1], glyph_y}
              + $signed({{(gbb_pkg::DIM_W-gbb_pkg::SIZE_W+1){1'b0}}, cell_row});
    in_buf    = !bx[gbb_pkg::DIM_W] && !by[gbb_pkg::DIM_W]
              && (bx[gbb_pkg::DIM_W-1:0] < pitch) && (by[gbb_pkg::DIM_W-1:0] < height);
    col_inc   = {1'b0, cell_col} + 1'b1;
    col_wrap  = (col_inc >= {1'b0, s});
  end

  assign w_free    = !w.valid || w_take;
  assign step      = b_valid && w_free;
  assign last_step = step && (bit_idx == '0);
  assign q_pop     = q_valid && (!b_valid || last_step);

  // pixel stage toward the emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      w.valid <= 1'b0;
    end else if (step) begin
      w.valid <= 1'b1;
      w.write <= !exhausted && hit && in_buf;
      w.eob   <= (bit_idx == '0);
      w.x     <= bx[gbb_pkg::DIM_W-1:0];
      w.y     <= by[gbb_pkg::DIM_W-1:0];
    end else if (w_take) begin
      w.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      val <= q_item.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      bit_idx      <= '0;
      pixel_count  <= '0;
      cell_row     <= '0;
      cell_col     <= '0;
      glyph_x      <= '0;
      glyph_y      <= '0;
      glyph_narrow <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid <= 1'b1;
        bit_idx <= gbb_pkg::BIT_W'(gbb_pkg::TOP_BIT);
      end else if (last_step) begin
        b_valid <= 1'b0;
      end else if (step) begin
        bit_idx <= bit_idx - 1'b1;
      end

      // glyph start on the incoming byte wins over the finishing step
      if (q_pop && q_item.start) begin
        glyph_x      <= q_item.ox;
        glyph_y      <= q_item.oy;
        glyph_narrow <= q_item.narrow;
        pixel_count  <= '0;
        cell_row     <= '0;
        cell_col     <= '0;
      end else if (step && !exhausted) begin
        pixel_count <= pixel_count + 1'b1;
        if (col_wrap) begin
          cell_col <= '0;
          cell_row <= cell_row + 1'b1;
        end else begin
          cell_col <= col_inc[gbb_pkg::SIZE_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/gbb_emit.sv
`default_nettype none

module gbb_emit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [gbb_pkg::DIM_W-1:0]    pitch,
  input  wire gbb_pkg::step_t               w,
  output logic                              w_take,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [gbb_pkg::ADDR_W-1:0]        pixel_address,
  output logic                              last_write
);

  // one write is held back until it is known whether it is the byte's last
  logic                               h_valid;
  logic                               h_final;
  logic [gbb_pkg::ADDR_W-1:0]         h_addr;
  logic                               o_free;
  logic                               h_emit_want;
  logic                               h_emit;
  logic                               emit_last;
  logic [2*gbb_pkg::DIM_W-1:0]        prod;
  logic [2*gbb_pkg::DIM_W-1:0]        addr_sum;

  assign prod     = w.y * pitch;
  assign addr_sum = prod + {{gbb_pkg::DIM_W{1'b0}}, w.x};

  assign o_free      = !out_valid || !out_stall;
  assign h_emit_want = h_valid && (h_final || (w.valid && (w.write || w.eob)));
  assign h_emit      = h_emit_want && o_free;
  assign emit_last   = h_final || (w.valid && w.eob && !w.write);
  assign w_take      = w.valid && (!(h_valid && (w.write || w.eob)) || h_emit);

  always_ff @(posedge clk) begin
    if (w_take && w.write) begin
      h_final <= w.eob;
      h_addr  <= addr_sum[gbb_pkg::ADDR_W-1:0];
    end
    if (h_emit) begin
      pixel_address <= h_addr;
      last_write    <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (w_take && w.write) begin
        h_valid <= 1'b1;
      end else if (h_emit) begin
        h_valid <= 1'b0;
      end
      if (h_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/glyph_bitmap_blit.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_stall  | code_byte, glyph_start, origin_x, origin_y,
//          |                      | narrow_cell
// out      | out_valid/out_stall  | pixel_address, pixel_color, last_write
// cfg      | cfg_write            | cfg_index, cfg_data
//
// Each byte's six bits are walked one bit per cycle while the pixel stage is
// free; the next byte is popped on the last bit's step. The block gives at most
// one write per cycle, and a write may be held while it waits to learn whether
// it is the byte's last.
// Synchronous active-high reset clears the queue, walk state and registers.
// A stall at the output backs up through the walker into the 2-entry queue.

module glyph_bitmap_blit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        code_byte,
  input  wire logic                              glyph_start,
  input  wire logic signed [gbb_pkg::DIM_W-1:0]  origin_x,
  input  wire logic signed [gbb_pkg::DIM_W-1:0]  origin_y,
  input  wire logic                              narrow_cell,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [gbb_pkg::ADDR_W-1:0]             pixel_address,
  output logic [gbb_pkg::COLOR_W-1:0]            pixel_color,
  output logic                                   last_write,
  input  wire logic                              cfg_write,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [gbb_pkg::CFG_W-1:0]         cfg_data
);

  logic [gbb_pkg::SIZE_W-1:0]  font_size;
  logic [gbb_pkg::DIM_W-1:0]   row_pitch;
  logic [gbb_pkg::DIM_W-1:0]   buffer_height;
  logic [gbb_pkg::COLOR_W-1:0] ink_color;
  logic [gbb_pkg::DIM_W-1:0]   pitch;
  logic [gbb_pkg::DIM_W-1:0]   height;

  logic            q_valid;
  gbb_pkg::item_t  q_item;
  logic            q_pop;
  gbb_pkg::step_t  w;
  logic            w_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      font_size     <= gbb_pkg::SIZE_W'(gbb_pkg::DEFAULT_SIZE);
      row_pitch     <= 11'd320;
      buffer_height <= 11'd240;
      ink_color     <= 16'hffff;
    end else if (cfg_write) begin
      case (cfg_index)
        gbb_pkg::CFG_FONT_SIZE:     font_size     <= cfg_data[gbb_pkg::SIZE_W-1:0];
        gbb_pkg::CFG_ROW_PITCH:     row_pitch     <= cfg_data[gbb_pkg::DIM_W-1:0];
        gbb_pkg::CFG_BUFFER_HEIGHT: buffer_height <= cfg_data[gbb_pkg::DIM_W-1:0];
        gbb_pkg::CFG_INK_COLOR:     ink_color     <= cfg_data[gbb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pitch       = gbb_pkg::clamp_dim(row_pitch);
  assign height      = gbb_pkg::clamp_dim(buffer_height);
  assign pixel_color = ink_color;

  gbb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .code_byte   (code_byte),
    .glyph_start (glyph_start),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .narrow_cell (narrow_cell),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  gbb_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .font_size (font_size),
    .pitch     (pitch),
    .height    (height),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .w         (w),
    .w_take    (w_take)
  );

  gbb_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .pitch         (pitch),
    .w             (w),
    .w_take        (w_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_address (pixel_address),
    .last_write    (last_write)
  );

endmodule

`default_nettype wire
